/* hdl/chsc_pkg.sv */
// ----------------------------------------------------------------------------
// chsc_pkg: shared types and constants of the chassis speed controller
// Field widths, word layouts, register codes, reset values and the
// control structs that pass between the stages.
// ----------------------------------------------------------------------------
package chsc_pkg;

  localparam int WHEEL_COUNT            = 4;
  localparam int DEF_GAIN_FRACTION_BITS = 12;

  // field widths
  localparam int STICK_W      = 11;
  localparam int SW_W         = 2;
  localparam int FB_W         = 16;
  localparam int AGE_W        = 16;
  localparam int CUR_W        = 16;
  localparam int SERVO_W      = 10;

  // register widths
  localparam int GAIN_W       = 20;
  localparam int LIMIT_W      = 15;
  localparam int DEADBAND_W   = 10;
  localparam int STICK_GAIN_W = 4;
  localparam int SPEED_W      = 14;
  localparam int CFG_W        = 20;
  localparam int CFG_IDX_W    = 3;

  // internal widths
  localparam int VEL_W  = 16;                // shaped vx, vy, vw
  localparam int ERR_W  = 18;                // wheel target and error
  localparam int DERR_W = ERR_W + 1;         // error difference
  localparam int P_W    = GAIN_W + 1 + ERR_W;
  localparam int D_W    = GAIN_W + 1 + DERR_W;

  // input word layout, lowest bit first
  localparam int OFS_FWD  = 0;
  localparam int OFS_STR  = OFS_FWD + STICK_W;
  localparam int OFS_ROT  = OFS_STR + STICK_W;
  localparam int OFS_RSW  = OFS_ROT + STICK_W;
  localparam int OFS_LSW  = OFS_RSW + SW_W;
  localparam int OFS_FB   = OFS_LSW + SW_W;
  localparam int OFS_RAGE = OFS_FB + WHEEL_COUNT * FB_W;
  localparam int OFS_MAGE = OFS_RAGE + AGE_W;
  localparam int IN_BITS  = OFS_MAGE + AGE_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // output word layout, lowest bit first
  localparam int OFS_SERVO   = WHEEL_COUNT * CUR_W;
  localparam int OFS_BLOCKED = OFS_SERVO + SERVO_W;
  localparam int OUT_BITS    = OFS_BLOCKED + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEGRAL_GAIN  = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_OUTPUT_LIMIT   = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_STICK_DEADBAND = 3'd5,
    REG_STICK_GAIN     = 3'd6,
    REG_SPEED_LIMIT    = 3'd7
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0]       RST_PROP_GAIN      = 20'd61440;
  localparam logic [GAIN_W-1:0]       RST_INTEGRAL_GAIN  = 20'd410;
  localparam logic [GAIN_W-1:0]       RST_DERIV_GAIN     = 20'd0;
  localparam logic [LIMIT_W-1:0]      RST_OUTPUT_LIMIT   = 15'd5000;
  localparam logic [LIMIT_W-1:0]      RST_INTEGRAL_LIMIT = 15'd3000;
  localparam logic [DEADBAND_W-1:0]   RST_STICK_DEADBAND = 10'd30;
  localparam logic [STICK_GAIN_W-1:0] RST_STICK_GAIN     = 4'd7;
  localparam logic [SPEED_W-1:0]      RST_SPEED_LIMIT    = 14'd7000;

  localparam logic [SW_W-1:0]  SW_UP   = 2'd1;
  localparam logic [SW_W-1:0]  SW_DOWN = 2'd2;

  localparam logic [AGE_W-1:0] REMOTE_TIMEOUT_MS = 16'd100;
  localparam logic [AGE_W-1:0] MOTOR_TIMEOUT_MS  = 16'd50;

  localparam logic [SERVO_W-1:0] SERVO_MIN   = 10'd550;
  localparam logic [SERVO_W-1:0] SERVO_MAX   = 10'd740;
  localparam logic [SERVO_W-1:0] SERVO_RESET = 10'd700;

  // inverse kinematics: bit i set means lane i takes the term negated;
  // vw enters every lane negated
  localparam logic [WHEEL_COUNT-1:0] LANE_VX_NEG = 4'b0110;
  localparam logic [WHEEL_COUNT-1:0] LANE_VY_NEG = 4'b0011;

  typedef struct packed {
    logic [DEADBAND_W-1:0]   deadband;
    logic [STICK_GAIN_W-1:0] stick_gain;
    logic [SPEED_W-1:0]      speed_limit;
  } shape_cfg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0] out_limit;
    logic [LIMIT_W-1:0] int_limit;
  } pid_cfg_t;

  typedef struct packed {
    logic signed [VEL_W-1:0]        vx;
    logic signed [VEL_W-1:0]        vy;
    logic signed [VEL_W-1:0]        vw;
    logic [WHEEL_COUNT-1:0][FB_W-1:0] fb;
    logic [SERVO_W-1:0]             servo;
    logic                           blocked;
  } shape_t;

  // per-stage load strobes of the lane pipeline
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } lane_load_t;

endpackage

/* hdl/chsc_shaper.sv */
// ----------------------------------------------------------------------------
// chsc_shaper: stick shaping, safety gate and servo ramp
// Negates strafe and rotate, applies deadband, gain and speed clamp,
// zeroes motion on timeout or safety switch, and steps the servo pulse.
// ----------------------------------------------------------------------------
module chsc_shaper
  import chsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [IN_TDATA_W-1:0] in_data,
  input  shape_cfg_t            cfg,
  output shape_t                st
);

  localparam int PROD_W = STICK_W + 1 + STICK_GAIN_W + 1;

  logic [SERVO_W-1:0] servo_position;
  logic [SERVO_W-1:0] servo_position_next;

  logic signed [STICK_W:0] fwd_ext, str_ext, rot_ext;
  logic signed [STICK_W:0] str_neg, rot_neg;
  logic signed [VEL_W-1:0] vx, vy, vw;
  logic [SW_W-1:0]         rsw, lsw;
  logic [AGE_W-1:0]        rage, mage;
  logic                    blocked;

  function automatic logic signed [VEL_W-1:0] shape(input logic signed [STICK_W:0] v,
                                                     input shape_cfg_t c);
    logic [STICK_W:0]          mag;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  lim;
    logic signed [PROD_W-1:0]  res;
    mag  = v[STICK_W] ? (STICK_W+1)'(-v) : (STICK_W+1)'(v);
    prod = v * $signed({1'b0, c.stick_gain});
    lim  = $signed(PROD_W'(c.speed_limit));
    if (mag < (STICK_W+1)'(c.deadband)) begin
      res = '0;
    end else if (prod > lim) begin
      res = lim;
    end else if (prod < -lim) begin
      res = -lim;
    end else begin
      res = prod;
    end
    return res[VEL_W-1:0];
  endfunction

  assign fwd_ext = $signed((STICK_W+1)'($signed(in_data[OFS_FWD +: STICK_W])));
  assign str_ext = $signed((STICK_W+1)'($signed(in_data[OFS_STR +: STICK_W])));
  assign rot_ext = $signed((STICK_W+1)'($signed(in_data[OFS_ROT +: STICK_W])));
  assign str_neg = -str_ext;
  assign rot_neg = -rot_ext;

  assign rsw  = in_data[OFS_RSW +: SW_W];
  assign lsw  = in_data[OFS_LSW +: SW_W];
  assign rage = in_data[OFS_RAGE +: AGE_W];
  assign mage = in_data[OFS_MAGE +: AGE_W];

  // an age equal to its limit still counts as online
  assign blocked = (rage > REMOTE_TIMEOUT_MS) || (mage > MOTOR_TIMEOUT_MS) ||
                   (rsw == SW_DOWN);

  assign vx = blocked ? '0 : shape(fwd_ext, cfg);
  assign vy = blocked ? '0 : shape(str_neg, cfg);
  assign vw = blocked ? '0 : shape(rot_neg, cfg);

  // position always sits inside the window, so a step only needs one bound
  always_comb begin
    servo_position_next = servo_position;
    case (lsw)
      SW_UP: begin
        if (servo_position < SERVO_MAX) servo_position_next = servo_position + 1'b1;
      end
      SW_DOWN: begin
        if (servo_position > SERVO_MIN) servo_position_next = servo_position - 1'b1;
      end
      default: servo_position_next = servo_position;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_position <= SERVO_RESET;
    end else if (load) begin
      servo_position <= servo_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st.vx      <= vx;
      st.vy      <= vy;
      st.vw      <= vw;
      st.fb      <= in_data[OFS_FB +: WHEEL_COUNT*FB_W];
      st.servo   <= servo_position_next;
      st.blocked <= blocked;
    end
  end

endmodule

/* hdl/chsc_pid_lane.sv */
// ----------------------------------------------------------------------------
// chsc_pid_lane: one wheel's target and PID pipeline
// Target and error, gain products, clamped integral, clamped sum.
// ----------------------------------------------------------------------------
module chsc_pid_lane
  import chsc_pkg::*;
#(
  parameter int GAIN_FRACTION_BITS = DEF_GAIN_FRACTION_BITS,
  parameter int LANE               = 0
)
(
  input  logic                                      clk,
  input  logic                                      rst,
  input  lane_load_t                                load,
  input  logic signed [VEL_W-1:0]                   vx,
  input  logic signed [VEL_W-1:0]                   vy,
  input  logic signed [VEL_W-1:0]                   vw,
  input  logic signed [FB_W-1:0]                    fb,
  input  pid_cfg_t                                  cfg,
  output logic signed [CUR_W+GAIN_FRACTION_BITS-1:0] sum
);

  localparam int F      = GAIN_FRACTION_BITS;
  localparam int SUM_W  = CUR_W + F;
  localparam int ISUM_W = CUR_W + F;
  localparam int ACC_W  = ((P_W > ISUM_W) ? P_W : ISUM_W) + 1;
  localparam int PD_W   = ((P_W > D_W) ? P_W : D_W) + 1;
  localparam int TOT_W  = ((PD_W > ISUM_W) ? PD_W : ISUM_W) + 1;

  // stage 2: error
  logic signed [ERR_W-1:0] tx, ty, tgt, err;
  logic signed [ERR_W-1:0] e2, pe2, prev_e;

  // stage 3: products
  logic signed [DERR_W-1:0] de;
  logic signed [P_W-1:0]    p3, i3;
  logic signed [D_W-1:0]    d3;

  // stage 4: integral
  logic signed [ACC_W-1:0]  isum_add, ilim;
  logic signed [ISUM_W-1:0] isum, isum_next, isum4;
  logic signed [PD_W-1:0]   pd4;

  // stage 5: total
  logic signed [TOT_W-1:0]  tot, olim;
  logic signed [SUM_W-1:0]  sum_next;

  assign tx  = LANE_VX_NEG[LANE] ? -ERR_W'(vx) : ERR_W'(vx);
  assign ty  = LANE_VY_NEG[LANE] ? -ERR_W'(vy) : ERR_W'(vy);
  assign tgt = tx + ty - ERR_W'(vw);
  assign err = tgt - ERR_W'(fb);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_e <= '0;
    end else if (load.s2) begin
      prev_e <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (load.s2) begin
      e2  <= err;
      pe2 <= prev_e;
    end
  end

  assign de = DERR_W'(e2) - DERR_W'(pe2);

  always_ff @(posedge clk) begin
    if (load.s3) begin
      p3 <= $signed({1'b0, cfg.kp}) * e2;
      i3 <= $signed({1'b0, cfg.ki}) * e2;
      d3 <= $signed({1'b0, cfg.kd}) * de;
    end
  end

  assign isum_add = ACC_W'(isum) + ACC_W'(i3);
  assign ilim     = $signed(ACC_W'({cfg.int_limit, F'(0)}));

  always_comb begin
    if (isum_add > ilim) begin
      isum_next = ISUM_W'(ilim);
    end else if (isum_add < -ilim) begin
      isum_next = ISUM_W'(-ilim);
    end else begin
      isum_next = ISUM_W'(isum_add);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      isum <= '0;
    end else if (load.s4) begin
      isum <= isum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load.s4) begin
      isum4 <= isum_next;
      pd4   <= PD_W'(p3) + PD_W'(d3);
    end
  end

  assign tot  = TOT_W'(pd4) + TOT_W'(isum4);
  assign olim = $signed(TOT_W'({cfg.out_limit, F'(0)}));

  always_comb begin
    if (tot > olim) begin
      sum_next = SUM_W'(olim);
    end else if (tot < -olim) begin
      sum_next = SUM_W'(-olim);
    end else begin
      sum_next = SUM_W'(tot);
    end
  end

  always_ff @(posedge clk) begin
    if (load.s5) begin
      sum <= sum_next;
    end
  end

endmodule

/* hdl/chsc_merge.sv */
// ----------------------------------------------------------------------------
// chsc_merge: result word assembly and output register
// Scales the four lane sums back to whole units, rounding toward zero,
// and packs them with the servo pulse and the blocked flag.
// ----------------------------------------------------------------------------
module chsc_merge
  import chsc_pkg::*;
#(
  parameter int GAIN_FRACTION_BITS = DEF_GAIN_FRACTION_BITS
)
(
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                in_valid,
  input  logic [WHEEL_COUNT-1:0][CUR_W+GAIN_FRACTION_BITS-1:0] lane_sum,
  input  logic [SERVO_W-1:0]                                  servo,
  input  logic                                                blocked,
  output logic                                                in_ready,
  output logic                                                m_tvalid,
  input  logic                                                m_tready,
  output logic [OUT_TDATA_W-1:0]                              m_tdata
);

  localparam int F     = GAIN_FRACTION_BITS;
  localparam int SUM_W = CUR_W + F;

  logic [WHEEL_COUNT-1:0][CUR_W-1:0] cur;

  // bias negative sums by 2^F-1 so the shift truncates toward zero
  always_comb begin
    for (int w = 0; w < WHEEL_COUNT; w++) begin
      logic signed [SUM_W:0] biased;
      biased = $signed((SUM_W+1)'($signed(lane_sum[w])));
      if (lane_sum[w][SUM_W-1]) begin
        biased = biased + $signed((SUM_W+1)'({F{1'b1}}));
      end
      cur[w] = CUR_W'(biased >>> F);
    end
  end

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_tdata <= {(OUT_TDATA_W-OUT_BITS)'(0), blocked, servo, cur};
    end
  end

endmodule

/* hdl/mecanum_chassis_speed_controller_top.sv */
// ----------------------------------------------------------------------------
// mecanum_chassis_speed_controller_top: mecanum chassis speed controller
// Stick shaping, safety gate, inverse kinematics and four PID lanes.
// ----------------------------------------------------------------------------
// One input word per control tick gives one output word with four wheel
// current commands, the servo pulse and the motion-blocked flag. The block
// takes a word every clock cycle while the output is not stalled; a word
// passes through the shaping stage, four lane stages and the output
// register. Each lane carries its integral and last error from tick to
// tick, so the integral add and clamp is the loop that sets the per-lane
// throughput. A stall on the output side holds the whole pipeline,
// and bubbles in it are squeezed out so that new words keep coming in while
// a finished result waits. Configuration writes take effect at once and
// should be made while no word is in flight.
module mecanum_chassis_speed_controller_top
  import chsc_pkg::*;
#(
  parameter int GAIN_FRACTION_BITS = DEF_GAIN_FRACTION_BITS
)
(
  input  logic                   clk,
  input  logic                   rst,
  // stick_forward, stick_strafe, stick_rotate, right_switch, left_switch,
  // feedback_front_left, feedback_front_right, feedback_back_right,
  // feedback_back_left, remote_age_ms, oldest_motor_age_ms
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // current_front_left, current_front_right, current_back_right,
  // current_back_left, servo_pulse_width, motion_blocked
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int SUM_W = CUR_W + GAIN_FRACTION_BITS;

  shape_cfg_t shape_cfg;
  pid_cfg_t   pid_cfg;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en_out;
  lane_load_t load;

  shape_t st1;

  logic [SERVO_W-1:0] servo2, servo3, servo4, servo5;
  logic               blocked2, blocked3, blocked4, blocked5;

  logic [WHEEL_COUNT-1:0][SUM_W-1:0] lane_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      pid_cfg.kp             <= RST_PROP_GAIN;
      pid_cfg.ki             <= RST_INTEGRAL_GAIN;
      pid_cfg.kd             <= RST_DERIV_GAIN;
      pid_cfg.out_limit      <= RST_OUTPUT_LIMIT;
      pid_cfg.int_limit      <= RST_INTEGRAL_LIMIT;
      shape_cfg.deadband     <= RST_STICK_DEADBAND;
      shape_cfg.stick_gain   <= RST_STICK_GAIN;
      shape_cfg.speed_limit  <= RST_SPEED_LIMIT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:      pid_cfg.kp            <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_GAIN:  pid_cfg.ki            <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:     pid_cfg.kd            <= cfg_data[GAIN_W-1:0];
        REG_OUTPUT_LIMIT:   pid_cfg.out_limit     <= cfg_data[LIMIT_W-1:0];
        REG_INTEGRAL_LIMIT: pid_cfg.int_limit     <= cfg_data[LIMIT_W-1:0];
        REG_STICK_DEADBAND: shape_cfg.deadband    <= cfg_data[DEADBAND_W-1:0];
        REG_STICK_GAIN:     shape_cfg.stick_gain  <= cfg_data[STICK_GAIN_W-1:0];
        REG_SPEED_LIMIT:    shape_cfg.speed_limit <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or the stage after it advances
  assign en5 = !v5 || en_out;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  assign load.s2 = en2 && v1;
  assign load.s3 = en3 && v2;
  assign load.s4 = en4 && v3;
  assign load.s5 = en5 && v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // servo and blocked flag ride alongside the lanes
  always_ff @(posedge clk) begin
    if (load.s2) begin
      servo2   <= st1.servo;
      blocked2 <= st1.blocked;
    end
    if (load.s3) begin
      servo3   <= servo2;
      blocked3 <= blocked2;
    end
    if (load.s4) begin
      servo4   <= servo3;
      blocked4 <= blocked3;
    end
    if (load.s5) begin
      servo5   <= servo4;
      blocked5 <= blocked4;
    end
  end

  chsc_shaper u_shaper (
    .clk     (clk),
    .rst     (rst),
    .load    (s_tvalid && en1),
    .in_data (s_tdata),
    .cfg     (shape_cfg),
    .st      (st1)
  );

  for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_lane
    chsc_pid_lane #(
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
      .LANE               (w)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .load (load),
      .vx   (st1.vx),
      .vy   (st1.vy),
      .vw   (st1.vw),
      .fb   ($signed(st1.fb[w])),
      .cfg  (pid_cfg),
      .sum  (lane_sum[w])
    );
  end

  chsc_merge #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .lane_sum (lane_sum),
    .servo    (servo5),
    .blocked  (blocked5),
    .in_ready (en_out),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* hdl/chsc_checker.sv */
// ----------------------------------------------------------------------------
// chsc_checker: port-level checks on the controller's result stream
// Reset, stall hold, servo window and current range on the output side.
// ----------------------------------------------------------------------------
module chsc_checker
  import chsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam logic [CUR_W-1:0] CUR_MOST_NEG = {1'b1, {(CUR_W-1){1'b0}}};

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed or dropped");

  a_servo_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OFS_SERVO +: SERVO_W] >= SERVO_MIN &&
                 m_tdata[OFS_SERVO +: SERVO_W] <= SERVO_MAX)
    else $error("servo pulse outside its window");

  // symmetric clamp never yields the most negative code
  a_current_sym: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[0*CUR_W +: CUR_W] != CUR_MOST_NEG &&
                 m_tdata[1*CUR_W +: CUR_W] != CUR_MOST_NEG &&
                 m_tdata[2*CUR_W +: CUR_W] != CUR_MOST_NEG &&
                 m_tdata[3*CUR_W +: CUR_W] != CUR_MOST_NEG)
    else $error("current command outside symmetric range");

endmodule

bind mecanum_chassis_speed_controller_top chsc_checker u_chsc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
